/* hw/rtl/rack_loss_detector_defines.svh */
// Assertion macros used by the rack loss detector top level.
`ifndef RACK_LOSS_DETECTOR_DEFINES_SVH
`define RACK_LOSS_DETECTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define RLD_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);
`define RLD_ASSERT(label, prop, msg) `RLD_ASSERT_CLK(label, clock, reset, prop, msg)
`else
`define RLD_ASSERT_CLK(label, clk, rst, prop, msg)
`define RLD_ASSERT(label, prop, msg)
`endif
`endif

/* hw/rtl/rld_pkg.sv */
// Types and constants shared by the rack loss detector modules.
`timescale 1ns / 1ps

package rld_pkg;

   // Item commands.
   typedef enum logic [1:0] {
      CMD_ADVANCE    = 2'd0,
      CMD_SCAN_START = 2'd1,
      CMD_SCAN_SEG   = 2'd2
   } rld_cmd_type;

   // Bit positions in the segment flags.
   localparam int FLAG_SACKED         = 0;
   localparam int FLAG_LOST           = 1;
   localparam int FLAG_SACKED_RETRANS = 2;
   localparam int FLAG_RETRANS        = 3;

   localparam logic [31:0] RESET_MIN_REO_WINDOW = 32'd1000;
   localparam logic [31:0] RTT_UNKNOWN          = 32'hFFFF_FFFF;

   localparam int LOST_COUNT_WIDTH_DEFAULT = 16;
   localparam int RSP_LOST_WIDTH           = 16;

   // One input item as held in the input register.
   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] seg_end_seq;
      logic [63:0] seg_send_time;
      logic [63:0] now_time;
      logic [31:0] min_rtt;
      logic [31:0] una_seq;
      logic [3:0]  seg_flags;
      logic        reordering_seen;
      logic        no_losses_pending;
   } rld_item_type;

   // One result item.
   typedef struct packed {
      logic [3:0]                seg_flags_out;
      logic                      newly_lost;
      logic                      retrans_dropped;
      logic                      stop_scan;
      logic [31:0]               reo_timeout_us;
      logic                      was_advanced;
      logic [RSP_LOST_WIDTH-1:0] lost_in_scan;
   } rld_result_type;

   // Scan status seen by the top level.
   typedef struct packed {
      logic                      scan_stopped;
      logic                      advanced;
      logic [RSP_LOST_WIDTH-1:0] lost_count;
   } rld_status_type;

endpackage

/* hw/rtl/rld_req_if.sv */
// Request channel interface carrying one input item per transfer.
`timescale 1ns / 1ps

interface rld_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] seg_end_seq;
   logic [63:0] seg_send_time;
   logic [63:0] now_time;
   logic [31:0] min_rtt;
   logic [31:0] una_seq;
   logic [3:0]  seg_flags;
   logic        reordering_seen;
   logic        no_losses_pending;

   modport source (
      output valid, command, seg_end_seq, seg_send_time, now_time, min_rtt,
             una_seq, seg_flags, reordering_seen, no_losses_pending,
      input  ready
   );

   modport sink (
      input  valid, command, seg_end_seq, seg_send_time, now_time, min_rtt,
             una_seq, seg_flags, reordering_seen, no_losses_pending,
      output ready
   );
endinterface

/* hw/rtl/rld_rsp_if.sv */
// Response channel interface carrying one result item per transfer.
`timescale 1ns / 1ps

interface rld_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  seg_flags_out;
   logic        newly_lost;
   logic        retrans_dropped;
   logic        stop_scan;
   logic [31:0] reo_timeout_us;
   logic        was_advanced;
   logic [15:0] lost_in_scan;

   modport source (
      output valid, seg_flags_out, newly_lost, retrans_dropped, stop_scan,
             reo_timeout_us, was_advanced, lost_in_scan,
      input  ready
   );

   modport sink (
      input  valid, seg_flags_out, newly_lost, retrans_dropped, stop_scan,
             reo_timeout_us, was_advanced, lost_in_scan,
      output ready
   );
endinterface

/* hw/rtl/rld_engine.sv */
// RACK state registers and the combinational evaluation of one item.
`timescale 1ns / 1ps

module rld_engine #(
   parameter int LOST_COUNT_WIDTH = rld_pkg::LOST_COUNT_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_en,
   input  rld_pkg::rld_item_type  item,
   input  logic [31:0]            min_reo_window,
   output rld_pkg::rld_result_type result,
   output rld_pkg::rld_status_type status
);
   import rld_pkg::*;

   localparam int CntW = (LOST_COUNT_WIDTH < RSP_LOST_WIDTH) ?
                         LOST_COUNT_WIDTH : RSP_LOST_WIDTH;

   // True when sequence a lies after b, with 32-bit wrap.
   function automatic logic seq_after(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] diff;
      diff = b - a;
      return diff[31];
   endfunction

   // Send order: later time, or same time and later end sequence.
   function automatic logic sent_after(input logic [63:0] t1, input logic [63:0] t2,
                                       input logic [31:0] s1, input logic [31:0] s2);
      return (t1 > t2) || ((t1 == t2) && seq_after(s1, s2));
   endfunction

   // Elapsed time, zero when time runs backwards, saturated to 32 bits.
   function automatic logic [31:0] delta_us(input logic [63:0] later,
                                            input logic [63:0] earlier);
      logic [63:0] diff;
      diff = later - earlier;
      if (later <= earlier) begin
         return '0;
      end
      return (diff[63:32] != '0) ? '1 : diff[31:0];
   endfunction

   logic [63:0]     rack_send_time_ff, rack_send_time_in;
   logic [31:0]     rack_end_seq_ff, rack_end_seq_in;
   logic [31:0]     rack_rtt_ff, rack_rtt_in;
   logic            advanced_ff, advanced_in;
   logic [31:0]     reo_window_ff, reo_window_in;
   logic [63:0]     scan_now_ff, scan_now_in;
   logic [31:0]     scan_una_ff, scan_una_in;
   logic [31:0]     max_timeout_ff, max_timeout_in;
   logic            scan_stopped_ff, scan_stopped_in;
   logic [CntW-1:0] lost_counter_ff, lost_counter_in;

   logic        adv_older, adv_take;
   logic [31:0] adv_rtt;
   logic [31:0] start_quarter, start_window;
   logic        seg_eligible, seg_ahead, seg_expired;
   logic [31:0] seg_elapsed, seg_wait_sat;
   logic [32:0] seg_budget, seg_remain;
   logic [33:0] seg_wait;
   logic [3:0]  flags_out;
   logic        newly_lost, retrans_dropped, was_advanced;

   // Advance: accept a segment sent after the RACK segment, unless a retransmit under min RTT.
   assign adv_older = (rack_send_time_ff != '0) &&
                      !sent_after(item.seg_send_time, rack_send_time_ff,
                                  item.seg_end_seq, rack_end_seq_ff);
   assign adv_rtt   = delta_us(item.now_time, item.seg_send_time);
   assign adv_take  = !adv_older &&
                      !(item.seg_flags[FLAG_RETRANS] && (adv_rtt < item.min_rtt));

   // Scan start: the floor, raised to a quarter of a known min RTT under reordering or no losses.
   assign start_quarter = item.min_rtt >> 2;
   assign start_window  = ((item.reordering_seen || item.no_losses_pending) &&
                           (item.min_rtt != RTT_UNKNOWN) &&
                           (start_quarter > min_reo_window)) ?
                          start_quarter : min_reo_window;

   // Scan segment: wait is RTT plus window minus elapsed plus one, exact, saturated to 32 bits.
   assign seg_eligible = !scan_stopped_ff && seq_after(item.seg_end_seq, scan_una_ff) &&
                         !item.seg_flags[FLAG_SACKED];
   assign seg_ahead    = sent_after(rack_send_time_ff, item.seg_send_time,
                                    rack_end_seq_ff, item.seg_end_seq);
   assign seg_elapsed  = delta_us(scan_now_ff, item.seg_send_time);
   assign seg_budget   = {1'b0, rack_rtt_ff} + {1'b0, reo_window_ff};
   assign seg_expired  = seg_budget < {1'b0, seg_elapsed};
   assign seg_remain   = seg_budget - {1'b0, seg_elapsed};
   assign seg_wait     = {1'b0, seg_remain} + 34'd1;
   assign seg_wait_sat = (seg_wait[33:32] != 2'b00) ? '1 : seg_wait[31:0];

   // Next state and per-item outputs.
   always_comb begin
      rack_send_time_in = rack_send_time_ff;
      rack_end_seq_in   = rack_end_seq_ff;
      rack_rtt_in       = rack_rtt_ff;
      advanced_in       = advanced_ff;
      reo_window_in     = reo_window_ff;
      scan_now_in       = scan_now_ff;
      scan_una_in       = scan_una_ff;
      max_timeout_in    = max_timeout_ff;
      scan_stopped_in   = scan_stopped_ff;
      lost_counter_in   = lost_counter_ff;
      flags_out         = item.seg_flags;
      newly_lost        = 1'b0;
      retrans_dropped   = 1'b0;
      was_advanced      = 1'b0;
      case (item.command)
         CMD_ADVANCE: begin
            if (adv_take) begin
               rack_rtt_in       = adv_rtt;
               rack_send_time_in = item.seg_send_time;
               rack_end_seq_in   = item.seg_end_seq;
               advanced_in       = 1'b1;
            end
         end
         CMD_SCAN_START: begin
            was_advanced    = advanced_ff;
            advanced_in     = 1'b0;
            scan_now_in     = item.now_time;
            scan_una_in     = item.una_seq;
            reo_window_in   = start_window;
            max_timeout_in  = '0;
            scan_stopped_in = 1'b0;
            lost_counter_in = '0;
            flags_out       = '0;
         end
         CMD_SCAN_SEG: begin
            if (seg_eligible) begin
               if (seg_ahead) begin
                  if (seg_expired) begin
                     if (!item.seg_flags[FLAG_LOST]) begin
                        flags_out[FLAG_LOST] = 1'b1;
                        newly_lost           = 1'b1;
                        if (!(&lost_counter_ff)) begin
                           lost_counter_in = lost_counter_ff + 1'b1;
                        end
                     end
                     if (item.seg_flags[FLAG_SACKED_RETRANS]) begin
                        flags_out[FLAG_SACKED_RETRANS] = 1'b0;
                        retrans_dropped                = 1'b1;
                     end
                  end else if (!(item.seg_flags[FLAG_LOST] &&
                                 !item.seg_flags[FLAG_SACKED_RETRANS])) begin
                     if (seg_wait_sat > max_timeout_ff) begin
                        max_timeout_in = seg_wait_sat;
                     end
                  end
               end else if (!item.seg_flags[FLAG_RETRANS]) begin
                  scan_stopped_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // State update on each processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         rack_send_time_ff <= '0;
         rack_end_seq_ff   <= '0;
         rack_rtt_ff       <= '0;
         advanced_ff       <= 1'b0;
         reo_window_ff     <= '0;
         scan_now_ff       <= '0;
         scan_una_ff       <= '0;
         max_timeout_ff    <= '0;
         scan_stopped_ff   <= 1'b0;
         lost_counter_ff   <= '0;
      end else if (item_en) begin
         rack_send_time_ff <= rack_send_time_in;
         rack_end_seq_ff   <= rack_end_seq_in;
         rack_rtt_ff       <= rack_rtt_in;
         advanced_ff       <= advanced_in;
         reo_window_ff     <= reo_window_in;
         scan_now_ff       <= scan_now_in;
         scan_una_ff       <= scan_una_in;
         max_timeout_ff    <= max_timeout_in;
         scan_stopped_ff   <= scan_stopped_in;
         lost_counter_ff   <= lost_counter_in;
      end
   end

   // The result reports the scan state after this item; scan start cleared it.
   assign result.seg_flags_out   = flags_out;
   assign result.newly_lost      = newly_lost;
   assign result.retrans_dropped = retrans_dropped;
   assign result.stop_scan       = scan_stopped_in;
   assign result.reo_timeout_us  = max_timeout_in;
   assign result.was_advanced    = was_advanced;
   assign result.lost_in_scan    = RSP_LOST_WIDTH'(lost_counter_in);

   assign status.scan_stopped = scan_stopped_ff;
   assign status.advanced     = advanced_ff;
   assign status.lost_count   = RSP_LOST_WIDTH'(lost_counter_ff);

endmodule

/* hw/rtl/rack_loss_detector.sv */
// Top level of the RACK loss detector: handshake registers and configuration.
//
//   channel  direction  transfer carries
//   req      in         one command item (advance, scan start, scan segment)
//   rsp      out        one result item per known command
//   csr      in         write of min_reo_window, no read-back
//
// An item is held in the input register and leaves through the result register,
// which presents its result. One item is taken every cycle while the result
// register is not stalled; the combinational evaluation in the engine sets this.
// A stalled result register holds the item behind it in the input register.
// Reset clears the valid flags and the engine state and sets min_reo_window to 1000.
`timescale 1ns / 1ps

module rack_loss_detector #(
   parameter int LOST_COUNT_WIDTH = rld_pkg::LOST_COUNT_WIDTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [31:0]   csr_wr_data,
   rld_req_if.sink       req_chan,
   rld_rsp_if.source     rsp_chan
);
   import rld_pkg::*;

`include "rack_loss_detector_defines.svh"

   logic           item_vld_ff, item_vld_in;
   rld_item_type   item_ff;
   logic           rsp_vld_ff, rsp_vld_in;
   rld_result_type rsp_data_ff;
   logic [31:0]    min_reo_window_ff;

   logic           req_xfer, out_free, cmd_known, item_fire;
   logic           same_scan, rsp_lost_ok;
   rld_result_type result;
   rld_status_type status;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_reo_window_ff <= RESET_MIN_REO_WINDOW;
      end else if (csr_wr_en) begin
         min_reo_window_ff <= csr_wr_data;
      end
   end

   // Handshake control: an unknown command is dropped without a result.
   assign cmd_known = (item_ff.command == CMD_ADVANCE) ||
                      (item_ff.command == CMD_SCAN_START) ||
                      (item_ff.command == CMD_SCAN_SEG);
   assign out_free  = !rsp_vld_ff || rsp_chan.ready;
   assign item_fire = item_vld_ff && (out_free || !cmd_known);
   assign req_chan.ready = !item_vld_ff || item_fire;
   assign req_xfer  = req_chan.valid && req_chan.ready;

   assign item_vld_in = req_xfer || (item_vld_ff && !item_fire);
   assign rsp_vld_in  = (item_fire && cmd_known) || (rsp_vld_ff && !rsp_chan.ready);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else begin
         item_vld_ff <= item_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff.command           <= req_chan.command;
         item_ff.seg_end_seq       <= req_chan.seg_end_seq;
         item_ff.seg_send_time     <= req_chan.seg_send_time;
         item_ff.now_time          <= req_chan.now_time;
         item_ff.min_rtt           <= req_chan.min_rtt;
         item_ff.una_seq           <= req_chan.una_seq;
         item_ff.seg_flags         <= req_chan.seg_flags;
         item_ff.reordering_seen   <= req_chan.reordering_seen;
         item_ff.no_losses_pending <= req_chan.no_losses_pending;
      end
   end

   // Evaluation and RACK state.
   rld_engine #(
      .LOST_COUNT_WIDTH (LOST_COUNT_WIDTH)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .item_en        (item_fire),
      .item           (item_ff),
      .min_reo_window (min_reo_window_ff),
      .result         (result),
      .status         (status)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_fire && cmd_known) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid           = rsp_vld_ff;
   assign rsp_chan.seg_flags_out   = rsp_data_ff.seg_flags_out;
   assign rsp_chan.newly_lost      = rsp_data_ff.newly_lost;
   assign rsp_chan.retrans_dropped = rsp_data_ff.retrans_dropped;
   assign rsp_chan.stop_scan       = rsp_data_ff.stop_scan;
   assign rsp_chan.reo_timeout_us  = rsp_data_ff.reo_timeout_us;
   assign rsp_chan.was_advanced    = rsp_data_ff.was_advanced;
   assign rsp_chan.lost_in_scan    = rsp_data_ff.lost_in_scan;

   // Conditions watched by the checks below.
   assign same_scan   = !(item_fire && (item_ff.command == CMD_SCAN_START));
   assign rsp_lost_ok = !rsp_data_ff.newly_lost || rsp_data_ff.seg_flags_out[FLAG_LOST];

   // A held item stays until it is processed.
   `RLD_ASSERT(a_item_held, item_vld_ff && !item_fire |=> item_vld_ff, "input item lost")
   // Only a scan start reopens a stopped scan.
   `RLD_ASSERT(a_stop_sticky, status.scan_stopped && same_scan |=> status.scan_stopped, "reopened")
   // The lost count only grows within a scan.
   `RLD_ASSERT(a_lost_grows, same_scan |=> status.lost_count >= $past(status.lost_count), "fell")
   // A newly lost result always carries the lost flag.
   `RLD_ASSERT(a_lost_flag, rsp_vld_ff |-> rsp_lost_ok, "newly lost without lost flag")

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the RACK loss detector with directed and random traffic.
`timescale 1ns / 1ps

module tb_top;
   import rld_pkg::*;

   // Counter width as the block is built by default.
   localparam int          LOST_W        = LOST_COUNT_WIDTH_DEFAULT;
   localparam int          LOST_LIMIT    = (LOST_W >= 16) ? 65535 : (1 << LOST_W) - 1;
   localparam logic [1:0]  CMD_UNKNOWN   = 2'd3;
   localparam int          SETTLE_CYCLES = 6;
   localparam int          LONG_HOLD     = 300;
   localparam int          PHASE_ITEMS   = 80;

   typedef struct packed {
      rld_item_type   it;
      logic           typed;
      rld_result_type res;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   rld_req_if req_chan ();
   rld_rsp_if rsp_chan ();

   rack_loss_detector #(
      .LOST_COUNT_WIDTH (LOST_W)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   // Shadow copy of the detector state, advanced on every accepted transfer.
   logic [31:0] p_min_window = RESET_MIN_REO_WINDOW;
   logic [63:0] p_send_time  = '0;
   logic [31:0] p_end_seq    = '0;
   logic [31:0] p_rtt        = '0;
   logic        p_advanced   = 1'b0;
   logic [31:0] p_window     = '0;
   logic [63:0] p_scan_now   = '0;
   logic [31:0] p_scan_una   = '0;
   logic [31:0] p_max_wait   = '0;
   logic        p_stopped    = 1'b0;
   int          p_lost       = 0;

   rld_result_type loss_verdicts_q[$];
   dir_row_type    dir_tab[$];
   int             mismatch_count = 0;
   int             sent_items     = 0;
   int             tx_gap_pct     = 0;
   int             rx_stall_pct   = 0;
   int             hold_requests  = 0;
   int             holds_served   = 0;
   int             rx_stall       = 0;

   always #1 clock = ~clock;

   // Sequence a is later than b in 32-bit wrapped sequence space.
   function automatic bit seq_is_after(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = b - a;
      return d[31];
   endfunction

   function automatic bit sent_later(input logic [63:0] t1, input logic [63:0] t2,
                                     input logic [31:0] s1, input logic [31:0] s2);
      return (t1 > t2) || (t1 == t2 && seq_is_after(s1, s2));
   endfunction

   // Elapsed microseconds, zero when time runs backwards, saturated to 32 bits.
   function automatic logic [31:0] elapsed_us(input logic [63:0] later,
                                              input logic [63:0] earlier);
      logic [63:0] d;
      if (later <= earlier) return '0;
      d = later - earlier;
      return (d > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
   endfunction

   // Works out the result of one item; returns zero when the item yields none.
   function automatic bit rack_predict(input rld_item_type it, output rld_result_type r);
      bit          take;
      logic [31:0] rtt, q, el, wt;
      longint      rem, w;
      logic [3:0]  f;
      f = it.seg_flags;
      r = '0;
      r.seg_flags_out = f;
      case (it.command)
         CMD_ADVANCE: begin
            take = 1'b1;
            if (p_send_time != 0 &&
                !sent_later(it.seg_send_time, p_send_time, it.seg_end_seq, p_end_seq))
               take = 1'b0;
            rtt = elapsed_us(it.now_time, it.seg_send_time);
            if (take && f[FLAG_RETRANS] && rtt < it.min_rtt) take = 1'b0;
            if (take) begin
               p_rtt       = rtt;
               p_send_time = it.seg_send_time;
               p_end_seq   = it.seg_end_seq;
               p_advanced  = 1'b1;
            end
         end
         CMD_SCAN_START: begin
            r.was_advanced = p_advanced;
            p_advanced     = 1'b0;
            p_scan_now     = it.now_time;
            p_scan_una     = it.una_seq;
            p_window       = p_min_window;
            if ((it.reordering_seen || it.no_losses_pending) && it.min_rtt != RTT_UNKNOWN) begin
               q = it.min_rtt >> 2;
               if (q > p_window) p_window = q;
            end
            p_max_wait      = '0;
            p_stopped       = 1'b0;
            p_lost          = 0;
            r.seg_flags_out = '0;
         end
         CMD_SCAN_SEG: begin
            if (!p_stopped && seq_is_after(it.seg_end_seq, p_scan_una) && !f[FLAG_SACKED]) begin
               if (sent_later(p_send_time, it.seg_send_time, p_end_seq, it.seg_end_seq)) begin
                  el  = elapsed_us(p_scan_now, it.seg_send_time);
                  rem = longint'({32'd0, p_rtt}) + longint'({32'd0, p_window}) -
                        longint'({32'd0, el});
                  if (rem < 0) begin
                     if (!f[FLAG_LOST]) begin
                        r.seg_flags_out[FLAG_LOST] = 1'b1;
                        r.newly_lost = 1'b1;
                        if (p_lost < LOST_LIMIT) p_lost++;
                     end
                     if (f[FLAG_SACKED_RETRANS]) begin
                        r.seg_flags_out[FLAG_SACKED_RETRANS] = 1'b0;
                        r.retrans_dropped = 1'b1;
                     end
                  end else if (!(f[FLAG_LOST] && !f[FLAG_SACKED_RETRANS])) begin
                     w  = rem + 1;
                     wt = (w > longint'(64'h0000_0000_FFFF_FFFF)) ? 32'hFFFF_FFFF : w[31:0];
                     if (wt > p_max_wait) p_max_wait = wt;
                  end
               end else if (!f[FLAG_RETRANS]) begin
                  p_stopped = 1'b1;
               end
            end
         end
         default: return 1'b0;
      endcase
      if (it.command != CMD_SCAN_START) begin
         r.stop_scan      = p_stopped;
         r.reo_timeout_us = p_max_wait;
         r.lost_in_scan   = 16'(p_lost);
      end
      return 1'b1;
   endfunction

   function automatic rld_item_type mk_item(input logic [1:0] cmd, input logic [31:0] seq,
                                            input logic [63:0] snd, input logic [63:0] nw,
                                            input logic [31:0] mrtt, input logic [31:0] una,
                                            input logic [3:0] fl, input logic reord,
                                            input logic no_lost);
      rld_item_type it;
      it.command           = cmd;
      it.seg_end_seq       = seq;
      it.seg_send_time     = snd;
      it.now_time          = nw;
      it.min_rtt           = mrtt;
      it.una_seq           = una;
      it.seg_flags         = fl;
      it.reordering_seen   = reord;
      it.no_losses_pending = no_lost;
      return it;
   endfunction

   function automatic rld_result_type mk_res(input logic [3:0] fl, input logic nl,
                                             input logic rd, input logic stop,
                                             input logic [31:0] to, input logic adv,
                                             input logic [15:0] lost);
      rld_result_type r;
      r.seg_flags_out   = fl;
      r.newly_lost      = nl;
      r.retrans_dropped = rd;
      r.stop_scan       = stop;
      r.reo_timeout_us  = to;
      r.was_advanced    = adv;
      r.lost_in_scan    = lost;
      return r;
   endfunction

   task automatic add_row(input rld_item_type it, input logic typed, input rld_result_type res);
      dir_row_type row;
      row.it    = it;
      row.typed = typed;
      row.res   = res;
      dir_tab.push_back(row);
   endtask

   // Mostly no idling, otherwise a short gap and now and then a long one.
   function automatic int idle_length(input int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [31:0] pick_min_rtt(input int hi);
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 14) return 32'($urandom_range(0, hi));
      if (sel < 17) return RTT_UNKNOWN;
      return $urandom;
   endfunction

   // Offers one item, waits for its transfer and records the expected result.
   task automatic send_rack_item(input rld_item_type it, input logic typed = 1'b0,
                                 input rld_result_type typed_res = '0);
      int             gap;
      rld_result_type r;
      gap = idle_length(tx_gap_pct);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid             <= 1'b1;
      req_chan.command           <= it.command;
      req_chan.seg_end_seq       <= it.seg_end_seq;
      req_chan.seg_send_time     <= it.seg_send_time;
      req_chan.now_time          <= it.now_time;
      req_chan.min_rtt           <= it.min_rtt;
      req_chan.una_seq           <= it.una_seq;
      req_chan.seg_flags         <= it.seg_flags;
      req_chan.reordering_seen   <= it.reordering_seen;
      req_chan.no_losses_pending <= it.no_losses_pending;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (rack_predict(it, r)) loss_verdicts_q.push_back(typed ? typed_res : r);
      if (it.command != CMD_UNKNOWN) sent_items++;
   endtask

   // Stops offering and waits until every expected result has arrived.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (loss_verdicts_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_window(input logic [31:0] v);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      p_min_window  = v;
   endtask

   task automatic send_noise_item();
      send_rack_item(mk_item(2'($urandom_range(0, 3)), $urandom, {$urandom, $urandom},
                             {$urandom, $urandom}, $urandom, $urandom,
                             4'($urandom_range(0, 15)), 1'($urandom), 1'($urandom)));
   endtask

   // One flow: a few deliveries, a scan start and a run of segments to check.
   task automatic run_flow_episode();
      logic [63:0] t0, snd, nw;
      logic [31:0] s0, seq, una;
      logic [3:0]  fl;
      bit          burst;
      int          n_adv, n_seg;
      burst = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 3))
         0:       t0 = 64'($urandom_range(0, 5000));
         1:       t0 = {$urandom, $urandom};
         2:       t0 = 64'hFFFF_FFFF_FFFF_0000 | 64'($urandom_range(0, 65535));
         default: t0 = 64'd50_000_000 + 64'($urandom);
      endcase
      if (burst) t0 = 64'd50_000_000 + 64'($urandom);
      s0 = $urandom;

      n_adv = burst ? $urandom_range(1, 3) : $urandom_range(0, 4);
      repeat (n_adv) begin
         snd = t0 + 64'($urandom_range(0, 20000));
         if ($urandom_range(0, 9) == 0)
            nw = snd + {31'd0, 1'b1, 32'($urandom)};
         else if ($urandom_range(0, 19) == 0)
            nw = snd - 64'($urandom_range(1, 1000));
         else
            nw = snd + 64'($urandom_range(0, 30000));
         seq = s0 + 32'($urandom_range(0, 40)) * 32'd1000;
         send_rack_item(mk_item(CMD_ADVANCE, seq, snd, nw, pick_min_rtt(30000), $urandom,
                                4'($urandom_range(0, 15)), 1'($urandom), 1'($urandom)));
      end

      nw  = burst ? t0 + 64'd5_000_000 : t0 + 64'($urandom_range(0, 60000));
      una = s0 + 32'($urandom_range(0, 5)) * 32'd1000 - 32'd2000;
      send_rack_item(mk_item(CMD_SCAN_START, $urandom, {$urandom, $urandom}, nw,
                             pick_min_rtt(200000), una, 4'($urandom_range(0, 15)),
                             1'($urandom), 1'($urandom)));

      n_seg = burst ? $urandom_range(20, 30) : $urandom_range(2, 16);
      repeat (n_seg) begin
         fl = 4'($urandom_range(0, 15));
         if (burst) begin
            snd = t0 - 64'($urandom_range(1, 100000));
            seq = s0 + 32'($urandom_range(5, 40)) * 32'd1000;
            fl[FLAG_SACKED] = 1'b0;
            fl[FLAG_LOST]   = 1'b0;
         end else begin
            snd = t0 + 64'($urandom_range(0, 25000));
            seq = s0 + 32'($urandom_range(0, 40)) * 32'd1000 - 32'd1000;
            if ($urandom_range(0, 2) != 0) fl[FLAG_SACKED] = 1'b0;
         end
         send_rack_item(mk_item(CMD_SCAN_SEG, seq, snd, {$urandom, $urandom}, $urandom,
                                $urandom, fl, 1'($urandom), 1'($urandom)));
      end
   endtask

   // Compares one field and reports it when it differs.
   function automatic int field_diff(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   task automatic check_result();
      rld_result_type want;
      int             bad;
      if (loss_verdicts_q.size() == 0) begin
         $display("%0t: result with none expected, expected nothing, actual flags 0x%0h",
                  $time, rsp_chan.seg_flags_out);
         mismatch_count++;
         return;
      end
      want = loss_verdicts_q.pop_front();
      bad = field_diff("seg_flags_out", 32'(want.seg_flags_out),
                       32'(rsp_chan.seg_flags_out))
          + field_diff("newly_lost", 32'(want.newly_lost), 32'(rsp_chan.newly_lost))
          + field_diff("retrans_dropped", 32'(want.retrans_dropped),
                       32'(rsp_chan.retrans_dropped))
          + field_diff("stop_scan", 32'(want.stop_scan), 32'(rsp_chan.stop_scan))
          + field_diff("reo_timeout_us", want.reo_timeout_us, rsp_chan.reo_timeout_us)
          + field_diff("was_advanced", 32'(want.was_advanced), 32'(rsp_chan.was_advanced))
          + field_diff("lost_in_scan", 32'(want.lost_in_scan), 32'(rsp_chan.lost_in_scan));
      mismatch_count += bad;
   endtask

   // Result side: checks each transfer and stalls at random or for a long hold.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) check_result();
         if (rx_stall > 0) begin
            rx_stall--;
            rsp_chan.ready <= 1'b0;
         end else if (holds_served != hold_requests) begin
            holds_served++;
            rx_stall = LONG_HOLD - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rx_stall = idle_length(rx_stall_pct);
            if (rx_stall > 0) begin
               rx_stall--;
               rsp_chan.ready <= 1'b0;
            end else begin
               rsp_chan.ready <= 1'b1;
            end
         end
      end
   end

   // Hard limit on the run time.
   initial begin
      #1_000_000;
      $display("[rack_loss_detector] ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [31:0] windows [5];
      int          phase_start;
      clock                      = 1'b0;
      reset                      = 1'b1;
      csr_wr_en                  = 1'b0;
      csr_wr_data                = '0;
      req_chan.valid             = 1'b0;
      req_chan.command           = '0;
      req_chan.seg_end_seq       = '0;
      req_chan.seg_send_time     = '0;
      req_chan.now_time          = '0;
      req_chan.min_rtt           = '0;
      req_chan.una_seq           = '0;
      req_chan.seg_flags         = '0;
      req_chan.reordering_seen   = 1'b0;
      req_chan.no_losses_pending = 1'b0;
      rsp_chan.ready             = 1'b0;

      // Directed rows, run with the reset window of 1000 us.
      // Segment before any scan start: reset state, so the scan stops at once.
      add_row(mk_item(CMD_SCAN_SEG, 32'd1, '0, '0, '0, '0, 4'h0, 1'b0, 1'b0),
              1'b1, mk_res(4'h0, 1'b0, 1'b0, 1'b1, '0, 1'b0, '0));
      add_row(mk_item(CMD_UNKNOWN, '1, '1, '1, '1, '1, 4'hF, 1'b1, 1'b1), 1'b0, '0);
      add_row(mk_item(CMD_SCAN_START, '0, '0, 64'd1_000_000, RTT_UNKNOWN, 32'd100, 4'hF,
                      1'b1, 1'b1), 1'b1, mk_res(4'h0, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0));
      // First delivery, not a retransmit, is taken and its flags are echoed.
      add_row(mk_item(CMD_ADVANCE, 32'd1100, 64'd990_000, 64'd1_000_000, 32'd5000, '0,
                      4'h1, 1'b0, 1'b0), 1'b1, mk_res(4'h1, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0));
      // Retransmits with an RTT below the minimum, or an unknown minimum, are ignored.
      add_row(mk_item(CMD_ADVANCE, 32'd1200, 64'd995_000, 64'd1_000_000, 32'd10000, '0,
                      4'h8, 1'b0, 1'b0), 1'b0, '0);
      add_row(mk_item(CMD_ADVANCE, 32'd1200, 64'd995_000, 64'd1_001_000, RTT_UNKNOWN, '0,
                      4'h8, 1'b0, 1'b0), 1'b0, '0);
      // Time running backwards gives a zero RTT.
      add_row(mk_item(CMD_ADVANCE, 32'd1250, 64'd996_000, 64'd900_000, 32'd0, '0,
                      4'h0, 1'b0, 1'b0), 1'b0, '0);
      add_row(mk_item(CMD_ADVANCE, 32'd1300, 64'd998_000, 64'd1_008_000, 32'd5000, '0,
                      4'h8, 1'b0, 1'b0), 1'b0, '0);
      add_row(mk_item(CMD_ADVANCE, 32'd1000, 64'd980_000, 64'd1_009_000, 32'd0, '0,
                      4'h0, 1'b0, 1'b0), 1'b0, '0);
      add_row(mk_item(CMD_SCAN_START, '0, '0, 64'd1_010_000, 32'd40000, 32'd100, 4'h0,
                      1'b1, 1'b0), 1'b1, mk_res(4'h0, 1'b0, 1'b0, 1'b0, '0, 1'b1, '0));
      add_row(mk_item(CMD_SCAN_SEG, 32'd500, 64'd900_000, '0, '0, '0, 4'h1, 1'b0, 1'b0),
              1'b0, '0);
      add_row(mk_item(CMD_SCAN_SEG, 32'd600, 64'd900_000, '0, '0, '0, 4'h0, 1'b0, 1'b0),
              1'b0, '0);
      add_row(mk_item(CMD_SCAN_SEG, 32'd700, 64'd900_000, '0, '0, '0, 4'h6, 1'b0, 1'b0),
              1'b0, '0);
      add_row(mk_item(CMD_SCAN_SEG, 32'd800, 64'd997_000, '0, '0, '0, 4'h0, 1'b0, 1'b0),
              1'b0, '0);
      add_row(mk_item(CMD_SCAN_SEG, 32'd800, 64'd997_000, '0, '0, '0, 4'h2, 1'b0, 1'b0),
              1'b0, '0);
      add_row(mk_item(CMD_SCAN_SEG, 32'd50, 64'd900_000, '0, '0, '0, 4'h0, 1'b0, 1'b0),
              1'b0, '0);
      add_row(mk_item(CMD_SCAN_SEG, 32'd2000, 64'd1_005_000, '0, '0, '0, 4'h8, 1'b0, 1'b0),
              1'b0, '0);
      add_row(mk_item(CMD_SCAN_SEG, 32'd2000, 64'd1_005_000, '0, '0, '0, 4'h0, 1'b0, 1'b0),
              1'b0, '0);
      add_row(mk_item(CMD_SCAN_SEG, 32'd900, 64'd900_000, '0, '0, '0, 4'h0, 1'b0, 1'b0),
              1'b0, '0);
      // Extremes: all-ones times and sequence wrap around zero.
      add_row(mk_item(CMD_ADVANCE, '1, '1, '1, '0, '0, 4'h0, 1'b0, 1'b0), 1'b0, '0);
      add_row(mk_item(CMD_ADVANCE, '0, '1, '1, '0, '0, 4'h0, 1'b0, 1'b0), 1'b0, '0);
      add_row(mk_item(CMD_SCAN_START, '0, '0, '1, 32'hFFFF_FFFE, 32'hFFFF_FFF0, 4'h0,
                      1'b0, 1'b1), 1'b0, '0);
      add_row(mk_item(CMD_SCAN_SEG, 32'd5, '0, '0, '0, '0, 4'h4, 1'b0, 1'b0), 1'b0, '0);
      add_row(mk_item(CMD_SCAN_SEG, 32'd6, 64'hFFFF_FFFF_FFFF_FFFA, '0, '0, '0, 4'h0,
                      1'b0, 1'b0), 1'b0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) send_rack_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);

      // Random phases, each with its own reordering window floor and idling.
      windows = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'd20000, 32'($urandom_range(0, 100000))};
      foreach (windows[p]) begin
         write_min_window(windows[p]);
         if (p == 0) begin
            tx_gap_pct   = 0;
            rx_stall_pct = 0;
         end else if (p == 1) begin
            // The result side holds off while items keep coming, so the block backs up.
            tx_gap_pct   = 0;
            rx_stall_pct = 20;
            hold_requests++;
         end else begin
            tx_gap_pct   = $urandom_range(5, 50);
            rx_stall_pct = $urandom_range(5, 50);
         end
         phase_start = sent_items;
         while (sent_items - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(1, 6)) send_noise_item();
            end else begin
               run_flow_episode();
            end
            if ($urandom_range(0, 4) == 0) drain_results();
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[rack_loss_detector] OK");
      end else begin
         $display("[rack_loss_detector] ERROR");
      end
      $finish;
   end

endmodule

/* rack_loss_detector.f */
+incdir+hw/rtl
hw/rtl/rld_pkg.sv
hw/rtl/rld_req_if.sv
hw/rtl/rld_rsp_if.sv
hw/rtl/rld_engine.sv
hw/rtl/rack_loss_detector.sv
sim/tb_top.sv
